/* hw/rtl/clrs_pkg.sv */
package clrs_pkg;

    // Fixed geometry of the display and glyph upload
    localparam int LINE_CHARS  = 16;
    localparam int GLYPH_BYTES = 64;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    // Input command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ENABLE = 3'd1;
    localparam logic [2:0] CMD_TEXT   = 3'd2;
    localparam logic [2:0] CMD_GLYPH  = 3'd3;
    localparam logic [2:0] CMD_TABLE  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_RESTART_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_CURSOR_ROW      = 2'd1;
    localparam logic [1:0] CFG_PAUSE_TICKS     = 2'd2;

    // Display command bytes
    localparam logic [7:0] LCD_FUNC_SET    = 8'h38;
    localparam logic [7:0] LCD_DISP_OFF    = 8'h08;
    localparam logic [7:0] LCD_CLEAR       = 8'h01;
    localparam logic [7:0] LCD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] LCD_DISP_ON     = 8'h0C;
    localparam logic [7:0] LCD_CGRAM_ADDR0 = 8'h40;
    localparam logic [7:0] LCD_LINE1_ADDR  = 8'h80;
    localparam logic [7:0] LCD_LINE2_ADDR  = 8'hC0;

    // Character encoding
    localparam logic [7:0] CHR_A8     = 8'hA8;
    localparam logic [7:0] CHR_B8     = 8'hB8;
    localparam logic [7:0] ENC_A8     = 8'h40;
    localparam logic [7:0] ENC_B8     = 8'h41;
    localparam logic [7:0] CHR_TABLE0 = 8'hC0;

    // Refresh and init step marks
    localparam logic [6:0] STEP_LINE1 = 7'd1;
    localparam logic [6:0] STEP_LINE2 = 7'(LINE_CHARS + 2);
    localparam logic [6:0] STEP_LAST  = 7'(2 * LINE_CHARS + 2);
    localparam logic [6:0] STEP_INIT_LAST = 7'd6;
    localparam logic [4:0] TPTR_LINE2 = 5'(LINE_CHARS % 32);
    localparam logic [6:0] CGRAM_END  = 7'(GLYPH_BYTES);

    typedef struct packed {
        logic [2:0] command;
        logic [5:0] index;
        logic [7:0] value;
    } t_clrs_in;

    typedef struct packed {
        logic       register_select;
        logic [7:0] bus_byte;
    } t_clrs_out;

    // Where the outgoing byte comes from
    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_TEXT,
        SRC_GLYPH
    } t_src;

    // Sequencer decision for one word, handed to the store/encode stages
    typedef struct packed {
        logic       res;
        t_src       src;
        logic       rs;
        logic [7:0] lit_byte;
        logic [4:0] text_addr;
        logic [5:0] glyph_addr;
        logic       text_we;
        logic       glyph_we;
        logic       tab_we;
        logic [5:0] widx;
        logic [7:0] wval;
    } t_clrs_act;

    // Init command for steps 1..6
    function automatic logic [7:0] init_cmd(input logic [2:0] k);
        logic [7:0] b;
        b = LCD_FUNC_SET;
        case (k)
            3'd1:    b = LCD_FUNC_SET;
            3'd2:    b = LCD_DISP_OFF;
            3'd3:    b = LCD_CLEAR;
            3'd4:    b = LCD_ENTRY_MODE;
            3'd5:    b = LCD_DISP_ON;
            3'd6:    b = LCD_CGRAM_ADDR0;
            default: b = LCD_FUNC_SET;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/clrs_ctrl.sv */
module clrs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  clrs_pkg::t_clrs_in i_word,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    output logic              o_busy,
    output clrs_pkg::t_clrs_act o_act
);
    import clrs_pkg::*;

    // Input register
    logic     r_a_vld;
    t_clrs_in r_a;

    // Configuration
    logic [15:0] r_timeout;
    logic [2:0]  r_cursor;
    logic [7:0]  r_pause_ticks;

    // Sequencer state
    logic [6:0]  r_step, n_step;
    logic        r_pend, n_pend;
    logic        r_en, n_en;
    logic        r_last_en, n_last_en;
    logic [15:0] r_rc, n_rc;
    logic [7:0]  r_pause, n_pause;
    logic [6:0]  r_cgram, n_cgram;
    logic [5:0]  r_gptr, n_gptr;
    logic [4:0]  r_tptr, n_tptr;

    logic [16:0] rc_inc;
    logic [6:0]  st, st_inc, cg_inc;
    logic        pend;
    t_clrs_act   act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_accept;
        end
        if (i_accept) begin
            r_a <= i_word;
        end
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout     <= '0;
            r_cursor      <= '0;
            r_pause_ticks <= 8'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RESTART_TIMEOUT: r_timeout     <= i_cfg_data;
                CFG_CURSOR_ROW:      r_cursor      <= i_cfg_data[2:0];
                CFG_PAUSE_TICKS:     r_pause_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= '0;
            r_pend    <= 1'b0;
            r_en      <= 1'b0;
            r_last_en <= 1'b0;
            r_rc      <= '0;
            r_pause   <= '0;
            r_cgram   <= '0;
            r_gptr    <= '0;
            r_tptr    <= '0;
        end else begin
            r_step    <= n_step;
            r_pend    <= n_pend;
            r_en      <= n_en;
            r_last_en <= n_last_en;
            r_rc      <= n_rc;
            r_pause   <= n_pause;
            r_cgram   <= n_cgram;
            r_gptr    <= n_gptr;
            r_tptr    <= n_tptr;
        end
    end

    // One word per cycle: restart check, then refresh, display-off or init step
    always_comb begin
        n_step    = r_step;
        n_pend    = r_pend;
        n_en      = r_en;
        n_last_en = r_last_en;
        n_rc      = r_rc;
        n_pause   = r_pause;
        n_cgram   = r_cgram;
        n_gptr    = r_gptr;
        n_tptr    = r_tptr;
        rc_inc    = {1'b0, r_rc} + 17'd1;
        st        = r_step;
        pend      = r_pend;
        st_inc    = r_step + 7'd1;
        cg_inc    = r_cgram + 7'd1;
        act       = '0;
        act.src   = SRC_LIT;
        act.widx  = r_a.index;
        act.wval  = r_a.value;
        act.text_addr  = r_tptr;
        act.glyph_addr = r_gptr;

        if (r_a_vld) begin
            unique case (r_a.command)
                CMD_TICK: begin
                    // restart timeout
                    if (r_timeout == 16'd0) begin
                        n_rc = '0;
                    end else begin
                        if (rc_inc >= {1'b0, r_timeout}) begin
                            st     = '0;
                            pend   = 1'b1;
                            rc_inc = '0;
                        end
                        n_rc = rc_inc[15:0];
                    end
                    // enable change forces a restart
                    if (r_last_en != r_en) begin
                        n_last_en = r_en;
                        st        = '0;
                        pend      = 1'b1;
                    end
                    st_inc = st + 7'd1;
                    n_step = st;
                    n_pend = pend;

                    if (!pend) begin
                        if (r_en) begin
                            n_step  = st_inc;
                            act.res = 1'b1;
                            if (st_inc == STEP_LINE1) begin
                                n_tptr       = '0;
                                act.lit_byte = LCD_LINE1_ADDR;
                            end else if (st_inc == STEP_LINE2) begin
                                n_tptr       = TPTR_LINE2;
                                act.lit_byte = LCD_LINE2_ADDR;
                            end else begin
                                act.src = SRC_TEXT;
                                act.rs  = 1'b1;
                                n_tptr  = r_tptr + 5'd1;
                                if (st_inc >= STEP_LAST) begin
                                    n_step = '0;
                                end
                            end
                        end
                    end else if (!r_en) begin
                        act.res      = 1'b1;
                        act.lit_byte = LCD_DISP_OFF;
                        n_pend       = 1'b0;
                    end else if (r_pause != 8'd0) begin
                        n_pause = r_pause - 8'd1;
                    end else begin
                        n_step  = st_inc;
                        act.res = 1'b1;
                        if (st_inc >= STEP_LINE1 && st_inc <= STEP_INIT_LAST) begin
                            act.lit_byte = init_cmd(st_inc[2:0]);
                            n_pause      = r_pause_ticks;
                            if (st_inc == STEP_INIT_LAST) begin
                                n_cgram = '0;
                                n_gptr  = '0;
                            end
                        end else begin
                            // CGRAM upload, cursor row blanked
                            act.rs = 1'b1;
                            if (r_cgram[2:0] != r_cursor) begin
                                act.src = SRC_GLYPH;
                                n_gptr  = r_gptr + 6'd1;
                            end
                            n_cgram = cg_inc;
                            if (cg_inc >= CGRAM_END) begin
                                n_step = '0;
                                n_pend = 1'b0;
                            end
                        end
                    end
                end
                CMD_ENABLE: n_en = r_a.value[0];
                CMD_TEXT:   act.text_we  = ~r_a.index[5];
                CMD_GLYPH:  act.glyph_we = 1'b1;
                CMD_TABLE:  act.tab_we   = 1'b1;
                default: ;
            endcase
        end
    end

    assign o_act  = act;
    assign o_busy = r_a_vld;

endmodule

/* hw/rtl/clrs_encode.sv */
module clrs_encode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  clrs_pkg::t_clrs_act i_act,
    output logic [1:0]          o_inflight,
    output logic                o_push,
    output clrs_pkg::t_clrs_out o_word
);
    import clrs_pkg::*;

    // Stores with valid bits: an unwritten entry reads as zero
    logic [7:0]  mem_text  [32];
    logic [7:0]  mem_glyph [64];
    logic [7:0]  mem_tab   [64];
    logic [31:0] r_text_vld;
    logic [63:0] r_glyph_vld;
    logic [63:0] r_tab_vld;

    logic [7:0] r_text_q, r_glyph_q, r_tab_q;
    logic       r_text_qv, r_glyph_qv, r_tab_qv;

    // Stage B
    logic       r_b_res, r_b_tw, r_b_rs;
    t_src       r_b_src;
    logic [7:0] r_b_lit, r_b_wval;
    logic [5:0] r_b_widx;

    // Stage C
    logic       r_c_res, r_c_rs, r_c_tab;
    logic [7:0] r_c_byte;

    logic [7:0] chr, gbyte, b_byte;
    logic       b_tab;

    // Text and glyph stores, accessed by the sequencer stage
    always_ff @(posedge i_clk) begin
        if (i_act.text_we) begin
            mem_text[i_act.widx[4:0]] <= i_act.wval;
        end
        if (i_act.glyph_we) begin
            mem_glyph[i_act.widx] <= i_act.wval;
        end
        r_text_q  <= mem_text[i_act.text_addr];
        r_glyph_q <= mem_glyph[i_act.glyph_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_vld  <= '0;
            r_glyph_vld <= '0;
        end else begin
            if (i_act.text_we) begin
                r_text_vld[i_act.widx[4:0]] <= 1'b1;
            end
            if (i_act.glyph_we) begin
                r_glyph_vld[i_act.widx] <= 1'b1;
            end
        end
        r_text_qv  <= r_text_vld[i_act.text_addr];
        r_glyph_qv <= r_glyph_vld[i_act.glyph_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_res <= 1'b0;
            r_b_tw  <= 1'b0;
            r_c_res <= 1'b0;
        end else begin
            r_b_res <= i_act.res;
            r_b_tw  <= i_act.tab_we;
            r_c_res <= r_b_res;
        end
        r_b_src  <= i_act.src;
        r_b_rs   <= i_act.rs;
        r_b_lit  <= i_act.lit_byte;
        r_b_widx <= i_act.widx;
        r_b_wval <= i_act.wval;
        r_c_rs   <= r_b_rs;
        r_c_byte <= b_byte;
        r_c_tab  <= b_tab;
    end

    // Stage B: character encoding, table lookup launched for the upper codes
    assign chr   = r_text_qv ? r_text_q : 8'd0;
    assign gbyte = r_glyph_qv ? r_glyph_q : 8'd0;

    always_comb begin
        b_byte = r_b_lit;
        b_tab  = 1'b0;
        unique case (r_b_src)
            SRC_LIT:   b_byte = r_b_lit;
            SRC_GLYPH: b_byte = gbyte;
            SRC_TEXT: begin
                if (chr == CHR_A8) begin
                    b_byte = ENC_A8;
                end else if (chr == CHR_B8) begin
                    b_byte = ENC_B8;
                end else if (chr >= CHR_TABLE0) begin
                    b_byte = 8'd0;
                    b_tab  = 1'b1;
                end else begin
                    b_byte = chr;
                end
            end
            default: b_byte = r_b_lit;
        endcase
    end

    // Encode table: written and read in stage B so ticks and writes stay ordered
    always_ff @(posedge i_clk) begin
        if (r_b_tw) begin
            mem_tab[r_b_widx] <= r_b_wval;
        end
        r_tab_q <= mem_tab[chr[5:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_vld <= '0;
        end else if (r_b_tw) begin
            r_tab_vld[r_b_widx] <= 1'b1;
        end
        r_tab_qv <= r_tab_vld[chr[5:0]];
    end

    // Stage C: final byte
    assign o_push                 = r_c_res;
    assign o_word.register_select = r_c_rs;
    assign o_word.bus_byte        = r_c_tab ? (r_tab_qv ? r_tab_q : 8'd0) : r_c_byte;
    assign o_inflight             = {1'b0, r_b_res} + {1'b0, r_c_res};

endmodule

/* hw/rtl/clrs_fifo.sv */
module clrs_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  clrs_pkg::t_clrs_out i_word,
    input  logic                i_pop_ready,
    output logic                o_valid,
    output clrs_pkg::t_clrs_out o_word,
    output logic [clrs_pkg::FIFO_CW-1:0] o_count
);
    import clrs_pkg::*;

    t_clrs_out            r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_CW-1:0]   r_cnt;
    logic                 pop;

    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid & i_pop_ready;
    assign o_word  = r_mem[r_rd];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= FIFO_AW'((32'(r_wr) + 1) % FIFO_DEPTH);
            end
            if (pop) begin
                r_rd <= FIFO_AW'((32'(r_rd) + 1) % FIFO_DEPTH);
            end
            if (i_push && !pop) begin
                r_cnt <= r_cnt + FIFO_CW'(1);
            end else if (pop && !i_push) begin
                r_cnt <= r_cnt - FIFO_CW'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FIFO_CW'(FIFO_DEPTH))
        else $error("fifo count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < FIFO_CW'(FIFO_DEPTH)) || pop)
        else $error("fifo overflow");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == FIFO_CW'(FIFO_DEPTH)) |-> r_wr == r_rd)
        else $error("fifo pointers disagree with count");

endmodule

/* hw/rtl/char_lcd_refresh_sequencer.sv */
// Channel   Direction  Handshake                  Word
// input     in         i_in_valid / o_in_ready    i_in_data  (command, index, value)
// output    out        o_out_valid / i_out_ready  o_out_data (register_select, bus_byte)
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// One word accepted per cycle while o_in_ready is high; a result passes the input
// register, the store read, the encode table read and the queue write before it
// can leave, and waits in an eight-entry output queue until it is taken.
// o_in_ready drops only when the queue plus words in flight would fill it.
// Reset is synchronous and active low; all stores read as zero after reset.
module char_lcd_refresh_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  clrs_pkg::t_clrs_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output clrs_pkg::t_clrs_out o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import clrs_pkg::*;

    logic               accept;
    logic               a_busy;
    t_clrs_act          act;
    logic [1:0]         inflight;
    logic               push;
    t_clrs_out          push_word;
    logic [FIFO_CW-1:0] fifo_cnt;
    logic [FIFO_CW+1:0] credit_use;

    // Words in the queue or still on their way to it
    assign credit_use = (FIFO_CW+2)'(fifo_cnt) + (FIFO_CW+2)'(a_busy)
                      + (FIFO_CW+2)'(inflight);
    assign o_in_ready = credit_use < (FIFO_CW+2)'(FIFO_DEPTH);
    assign accept     = i_in_valid & o_in_ready;

    clrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_busy     (a_busy),
        .o_act      (act)
    );

    clrs_encode u_encode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_act      (act),
        .o_inflight (inflight),
        .o_push     (push),
        .o_word     (push_word)
    );

    clrs_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_word      (push_word),
        .i_pop_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_word      (o_out_data),
        .o_count     (fifo_cnt)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import clrs_pkg::*;

    localparam int NUM_PHASES  = 8;
    localparam int PHASE_WORDS = 150;
    localparam int DRAIN_GAP   = 8;
    localparam int LIMIT       = 500000;

    // Predicts the display bus bytes and holds them until the block sends them
    class lcd_scoreboard;
        logic [15:0] restart_timeout;
        logic [2:0]  cursor_row;
        logic [7:0]  pause_ticks;
        logic [6:0]  step;
        logic        restart_pending;
        logic        enable_flag;
        logic        last_enable;
        logic [15:0] restart_count;
        logic [7:0]  pause_count;
        logic [6:0]  cgram_addr;
        logic [5:0]  glyph_ptr;
        logic [4:0]  text_ptr;
        logic [7:0]  text_mem [32];
        logic [7:0]  glyph_mem [64];
        logic [7:0]  char_map [64];
        logic [7:0]  init_seq [6];
        t_clrs_out   expected_bytes [$];
        int          errors;

        function new();
            restart_timeout = '0;
            cursor_row      = '0;
            pause_ticks     = 8'd2;
            step            = '0;
            restart_pending = 1'b0;
            enable_flag     = 1'b0;
            last_enable     = 1'b0;
            restart_count   = '0;
            pause_count     = '0;
            cgram_addr      = '0;
            glyph_ptr       = '0;
            text_ptr        = '0;
            foreach (text_mem[i]) text_mem[i] = '0;
            foreach (glyph_mem[i]) glyph_mem[i] = '0;
            foreach (char_map[i]) char_map[i] = '0;
            init_seq = '{LCD_FUNC_SET, LCD_DISP_OFF, LCD_CLEAR,
                         LCD_ENTRY_MODE, LCD_DISP_ON, LCD_CGRAM_ADDR0};
            errors = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Advance the model by one accepted word
        function void note_word(t_clrs_in w);
            t_clrs_out   r;
            logic        has;
            logic [7:0]  c;
            int unsigned n;
            has = 1'b0;
            r   = '0;
            case (w.command)
                CMD_TICK: begin
                    // periodic and enable-change restart
                    if (restart_timeout == 16'd0) begin
                        restart_count = '0;
                    end else begin
                        n = restart_count + 1;
                        if (n >= restart_timeout) begin
                            step = '0;
                            restart_pending = 1'b1;
                            n = 0;
                        end
                        restart_count = n[15:0];
                    end
                    if (last_enable != enable_flag) begin
                        last_enable = enable_flag;
                        step = '0;
                        restart_pending = 1'b1;
                    end

                    if (!restart_pending) begin
                        // text refresh
                        if (enable_flag) begin
                            step = step + 7'd1;
                            if (step == STEP_LINE1) begin
                                text_ptr = '0;
                                r.register_select = 1'b0;
                                r.bus_byte = LCD_LINE1_ADDR;
                            end else if (step == STEP_LINE2) begin
                                text_ptr = TPTR_LINE2;
                                r.register_select = 1'b0;
                                r.bus_byte = LCD_LINE2_ADDR;
                            end else begin
                                c = text_mem[text_ptr];
                                if (c == CHR_A8) c = ENC_A8;
                                else if (c == CHR_B8) c = ENC_B8;
                                else if (c >= CHR_TABLE0) c = char_map[c[5:0]];
                                r.register_select = 1'b1;
                                r.bus_byte = c;
                                text_ptr = text_ptr + 5'd1;
                                if (step >= STEP_LAST) step = '0;
                            end
                            has = 1'b1;
                        end
                    end else if (!enable_flag) begin
                        r.register_select = 1'b0;
                        r.bus_byte = LCD_DISP_OFF;
                        restart_pending = 1'b0;
                        has = 1'b1;
                    end else if (pause_count != 8'd0) begin
                        pause_count = pause_count - 8'd1;
                    end else begin
                        // init command or CGRAM upload byte
                        step = step + 7'd1;
                        if (step >= 7'd1 && step <= STEP_INIT_LAST) begin
                            r.register_select = 1'b0;
                            r.bus_byte = init_seq[step - 7'd1];
                            pause_count = pause_ticks;
                            if (step == STEP_INIT_LAST) begin
                                cgram_addr = '0;
                                glyph_ptr = '0;
                            end
                        end else begin
                            r.register_select = 1'b1;
                            if (cgram_addr[2:0] != cursor_row) begin
                                r.bus_byte = glyph_mem[glyph_ptr];
                                glyph_ptr = glyph_ptr + 6'd1;
                            end else begin
                                r.bus_byte = 8'h00;
                            end
                            cgram_addr = cgram_addr + 7'd1;
                            if (cgram_addr >= CGRAM_END) begin
                                step = '0;
                                restart_pending = 1'b0;
                            end
                        end
                        has = 1'b1;
                    end
                end
                CMD_ENABLE: enable_flag = w.value[0];
                CMD_TEXT:   if (w.index < 6'd32) text_mem[w.index[4:0]] = w.value;
                CMD_GLYPH:  glyph_mem[w.index] = w.value;
                CMD_TABLE:  char_map[w.index] = w.value;
                default: ;
            endcase
            if (has) expected_bytes.push_back(r);
        endfunction

        // Compare one sent byte against the oldest prediction
        function void check_byte(t_clrs_out got);
            t_clrs_out exp;
            if (expected_bytes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: rs=%0d byte=%02h",
                             got.register_select, got.bus_byte);
                return;
            end
            exp = expected_bytes.pop_front();
            if (got.register_select !== exp.register_select ||
                got.bus_byte !== exp.bus_byte) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected rs=%0d byte=%02h, got rs=%0d byte=%02h",
                             exp.register_select, exp.bus_byte,
                             got.register_select, got.bus_byte);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_clrs_in    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_clrs_out   o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_idx   = '0;
    logic [15:0] i_cfg_data  = '0;

    lcd_scoreboard sb;
    int  rx_hold = 0;
    bit  rx_calm = 1'b0;
    int  cycle_count = 0;

    char_lcd_refresh_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_byte(o_out_data);
    end

    // Receiver: random stalls, one long hold on request, none when calm
    initial begin : rx_side
        int n;
        forever begin
            if (rx_hold > 0) begin
                n = rx_hold;
                rx_hold = 0;
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (rx_calm) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    function automatic t_clrs_in mk(logic [2:0] cmd, logic [5:0] idx, logic [7:0] val);
        t_clrs_in w;
        w.command = cmd;
        w.index   = idx;
        w.value   = val;
        return w;
    endfunction

    // Mostly ticks and content writes, a few enable changes and junk codes
    function automatic t_clrs_in random_word();
        t_clrs_in w;
        int pick;
        pick    = $urandom_range(0, 99);
        w.index = 6'($urandom_range(0, 63));
        w.value = 8'($urandom_range(0, 255));
        if (pick < 62) begin
            w.command = CMD_TICK;
        end else if (pick < 74) begin
            w.command = CMD_TEXT;
            if ($urandom_range(0, 99) < 85) w.index = 6'($urandom_range(0, 31));
            else w.index = 6'($urandom_range(32, 63));
            if ($urandom_range(0, 9) == 0) w.value = $urandom_range(0, 1) ? CHR_A8 : CHR_B8;
        end else if (pick < 82) begin
            w.command = CMD_GLYPH;
        end else if (pick < 90) begin
            w.command = CMD_TABLE;
        end else if (pick < 95) begin
            w.command = CMD_ENABLE;
            w.value[0] = ($urandom_range(0, 4) != 0);
        end else begin
            w.command = 3'($urandom_range(5, 7));
        end
        return w;
    endfunction

    // Offer one word and hold it until accepted
    task automatic send_word(input t_clrs_in w);
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(w);
    endtask

    task automatic idle_cycles(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending until every predicted byte has been sent
    task automatic wait_all_out();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Drain, then leave room for words still in the pipeline
    task automatic quiesce();
        wait_all_out();
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] tmo, input logic [2:0] row,
                              input logic [7:0] pause);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_RESTART_TIMEOUT;
        i_cfg_data <= tmo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CURSOR_ROW;
        i_cfg_data <= {13'($urandom), row};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PAUSE_TICKS;
        i_cfg_data <= {8'($urandom), pause};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.restart_timeout = tmo;
        sb.cursor_row      = row;
        sb.pause_ticks     = pause;
    endtask

    initial begin : main
        t_clrs_in    w;
        int          done;
        bit          paused;
        logic [15:0] tmo;
        logic [2:0]  row;
        logic [7:0]  pause;

        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle tick, junk codes, encoding corners, store extremes
        send_word(mk(CMD_TICK, 6'd0, 8'h00));
        send_word(mk(3'd5, 6'd63, 8'hFF));
        send_word(mk(3'd6, 6'd21, 8'h55));
        send_word(mk(3'd7, 6'd42, 8'hAA));
        send_word(mk(CMD_TEXT, 6'd0, CHR_A8));
        send_word(mk(CMD_TEXT, 6'd1, CHR_B8));
        send_word(mk(CMD_TEXT, 6'd2, CHR_TABLE0));
        send_word(mk(CMD_TEXT, 6'd3, 8'hFF));
        send_word(mk(CMD_TEXT, 6'd15, 8'hBF));
        send_word(mk(CMD_TEXT, 6'd16, 8'h7F));
        send_word(mk(CMD_TEXT, 6'd31, 8'h00));
        send_word(mk(CMD_TEXT, 6'd32, 8'h55));   // out of range, dropped
        send_word(mk(CMD_TEXT, 6'd63, 8'hAA));   // out of range, dropped
        send_word(mk(CMD_TABLE, 6'd0, 8'h5A));
        send_word(mk(CMD_TABLE, 6'd63, 8'hA5));
        send_word(mk(CMD_GLYPH, 6'd0, 8'hFF));
        send_word(mk(CMD_GLYPH, 6'd63, 8'h81));
        send_word(mk(CMD_GLYPH, 6'd1, 8'h00));
        send_word(mk(CMD_ENABLE, 6'd0, 8'hFF));
        repeat (6) send_word(mk(CMD_TICK, 6'd0, 8'h00));
        send_word(mk(CMD_ENABLE, 6'd63, 8'h00));
        send_word(mk(CMD_TICK, 6'd0, 8'h00));    // display off
        send_word(mk(CMD_TICK, 6'd0, 8'h00));    // disabled, nothing sent

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            quiesce();
            row   = 3'($urandom_range(0, 7));
            pause = 8'($urandom_range(0, 3));
            tmo   = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(70, 600));
            case (ph)
                0: begin tmo = 16'd0; row = 3'd7; pause = 8'd0; end
                1: begin tmo = 16'hFFFF; row = 3'd0; pause = 8'hFF; end
                2: begin tmo = 16'd1; pause = 8'd0; end
                3: begin tmo = 16'($urandom_range(80, 300)); pause = 8'($urandom_range(0, 2)); end
                default: ;
            endcase
            set_config(tmo, row, pause);
            rx_calm = (ph == NUM_PHASES - 1);
            if (ph == 3) rx_hold = 300;
            paused = 1'b0;
            send_word(mk(CMD_ENABLE, 6'($urandom), 8'h01));
            done = 1;
            while (done < PHASE_WORDS) begin
                w = random_word();
                send_word(w);
                if (w.command <= CMD_TABLE && !(w.command == CMD_TEXT && w.index >= 6'd32))
                    done++;
                if (ph == 5 && done >= 75 && !paused) begin
                    paused = 1'b1;
                    wait_all_out();
                end else if (!rx_calm && !(ph == 3 && done < 80) &&
                             $urandom_range(0, 5) == 0) begin
                    idle_cycles($urandom_range(1, 18));
                end
            end
        end

        quiesce();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/clrs_pkg.sv
hw/rtl/clrs_ctrl.sv
hw/rtl/clrs_encode.sv
hw/rtl/clrs_fifo.sv
hw/rtl/char_lcd_refresh_sequencer.sv
sim/testbench.sv
